[sv/dpct_pkg.sv]
`timescale 1ns / 1ps
// dpct_pkg: shared types, widths and register codes for the disk pair collision time core.
// No dependencies.

package dpct_pkg;

    localparam int WORD_BITS    = 32;
    localparam int FRAC_BITS    = 16;
    localparam int CFG_BITS     = 31;
    localparam int CFG_IDX_BITS = 2;
    localparam int QUEUE_DEPTH  = 4;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HALF_HEIGHT = 2'd2;

    localparam logic [CFG_BITS-1:0] RADIUS_RST      = 31'd65536;
    localparam logic [CFG_BITS-1:0] HALF_WIDTH_RST  = 31'd6553600;
    localparam logic [CFG_BITS-1:0] HALF_HEIGHT_RST = 31'd6553600;

    // |P|, nonnegative Q and V all fit in 2W+2 bits; D fits in 4W+4, its root in 2W+2
    localparam int PMAG_BITS = 2 * WORD_BITS + 2;
    localparam int D_BITS    = 2 * PMAG_BITS;
    localparam int ROOT_BITS = PMAG_BITS;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] pos_x_a;
        logic signed [WORD_BITS-1:0] pos_y_a;
        logic signed [WORD_BITS-1:0] vel_x_a;
        logic signed [WORD_BITS-1:0] vel_y_a;
        logic signed [WORD_BITS-1:0] pos_x_b;
        logic signed [WORD_BITS-1:0] pos_y_b;
        logic signed [WORD_BITS-1:0] vel_x_b;
        logic signed [WORD_BITS-1:0] vel_y_b;
    } in_item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] hit_time;
        logic                 never;
    } out_item_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] radius;
        logic [CFG_BITS-1:0] half_width;
        logic [CFG_BITS-1:0] half_height;
    } cfg_t;

    // Classified pair handed from front to back
    typedef struct packed {
        in_item_t             item;
        logic [PMAG_BITS-1:0] p_mag;
        logic [PMAG_BITS-1:0] q;
        logic [D_BITS-1:0]    d;
        logic                 never;
    } bridge_t;

endpackage

[sv/disk_pair_collision_time_core.sv]
`timescale 1ns / 1ps
// disk_pair_collision_time_core: top level, configuration registers, front, queue and back.
// Depends on dpct_pkg, dpct_front, dpct_fifo and dpct_back.
//
//   channel  direction  handshake             payload
//   pair     in         pair_valid/pair_stall dpct_pkg::in_item_t  (two disks)
//   hit      out        hit_valid/hit_stall   dpct_pkg::out_item_t (hit_time, never)
//   cfg      in         cfg_we                cfg_index, cfg_data (radius, half sizes)
//
// One pair transfer per cycle is sustained while the hit channel is not stalled. A pair
// passes the front stages F1 to F7, the queue, and then the back: root set-up, the root
// stages for 2*WORD_BITS+2 root bits, divider set-up, the quotient stages, the time
// register, the box multipliers and the output register.
// Reset clears valid bits, queue pointers and the configuration to its reset values;
// there is no clearing pass. A stalled hit freezes the back pipeline; the front keeps
// taking pairs until the queue fills, and only then raises pair_stall.

module disk_pair_collision_time_core #(
    parameter int FRAC_BITS   = dpct_pkg::FRAC_BITS,
    parameter int QUEUE_DEPTH = dpct_pkg::QUEUE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pair_valid,
    output logic                              pair_stall,
    input  dpct_pkg::in_item_t                pair,
    output logic                              hit_valid,
    input  logic                              hit_stall,
    output dpct_pkg::out_item_t               hit,
    input  logic                              cfg_we,
    input  logic [dpct_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [dpct_pkg::CFG_BITS-1:0]     cfg_data
);
    dpct_pkg::cfg_t    cfg_reg;
    dpct_pkg::bridge_t push_data;
    dpct_pkg::bridge_t head;
    logic              push, pop, full, not_empty;

    // Configuration registers; an unused index is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radius      <= dpct_pkg::RADIUS_RST;
            cfg_reg.half_width  <= dpct_pkg::HALF_WIDTH_RST;
            cfg_reg.half_height <= dpct_pkg::HALF_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dpct_pkg::REG_RADIUS:      cfg_reg.radius      <= cfg_data;
                dpct_pkg::REG_HALF_WIDTH:  cfg_reg.half_width  <= cfg_data;
                dpct_pkg::REG_HALF_HEIGHT: cfg_reg.half_height <= cfg_data;
                default: ;
            endcase
        end
    end

    // Front: differences, dot products, discriminant, early misses
    dpct_front u_front (
        .clk(clk), .rst_n(rst_n),
        .pair_valid(pair_valid), .pair_stall(pair_stall), .pair(pair),
        .radius(cfg_reg.radius),
        .full(full), .push(push), .push_data(push_data)
    );

    // Queue decouples front stalls from back stalls
    dpct_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_data(push_data),
        .pop(pop), .full(full), .not_empty(not_empty), .head(head)
    );

    // Back: root, stable-root division with saturation, box test, output register
    dpct_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(not_empty), .q_data(head), .pop(pop),
        .cfg(cfg_reg),
        .hit_valid(hit_valid), .hit_stall(hit_stall), .hit(hit)
    );

endmodule

[sv/dpct_mul.sv]
`timescale 1ns / 1ps
// dpct_mul: two-stage unsigned multiplier built from four half-width partial products.
// No dependencies.

module dpct_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic             clk,
    input  logic             en,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);
    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AL+BL-1:0] ll_reg;
    logic [AL+BH-1:0] lh_reg;
    logic [AH+BL-1:0] hl_reg;
    logic [AH+BH-1:0] hh_reg;
    logic [PW-1:0]    p_reg;
    logic [PW-1:0]    p_next;

    always_comb
    begin
        p_next = {hh_reg, {(AL+BL){1'b0}}}
               + (PW'(hl_reg) << AL)
               + (PW'(lh_reg) << BL)
               + PW'(ll_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= a[AL-1:0] * b[BL-1:0];
            lh_reg <= a[AL-1:0] * b[BW-1:BL];
            hl_reg <= a[AW-1:AL] * b[BL-1:0];
            hh_reg <= a[AW-1:AL] * b[BW-1:BL];
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

[sv/dpct_front.sv]
`timescale 1ns / 1ps
// dpct_front: takes pairs, forms P, Q, V and the discriminant, flags the trivial misses.
// Depends on dpct_pkg and dpct_mul.

module dpct_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pair_valid,
    output logic                     pair_stall,
    input  dpct_pkg::in_item_t       pair,
    input  logic [dpct_pkg::CFG_BITS-1:0] radius,
    input  logic                     full,
    output logic                     push,
    output dpct_pkg::bridge_t        push_data
);
    localparam int W    = dpct_pkg::WORD_BITS;
    localparam int MW   = W + 1;
    localparam int PM   = dpct_pkg::PMAG_BITS;
    localparam int PSW  = PM + 1;
    localparam int CB   = dpct_pkg::CFG_BITS;
    localparam int R4W  = 2 * CB + 2;
    localparam int QSW  = ((PM > R4W) ? PM : R4W) + 1;
    localparam int DW   = dpct_pkg::D_BITS;
    localparam int LAST = 6;

    logic            en;
    logic [LAST:0]   vld_reg;
    logic [2*CB-1:0] r2_reg;

    // F1: differences as magnitude and sign
    dpct_pkg::in_item_t f1_item_reg;
    logic [MW-1:0] mag_reg [0:3];
    logic [3:0]    sgn_reg;
    logic [MW-1:0] diff_c  [0:3];

    // F2, F3 ride alongside the first multipliers
    dpct_pkg::in_item_t f2_item_reg, f3_item_reg;
    logic [1:0] f2_sgn_reg, f3_sgn_reg;
    logic [PM-1:0] pxx, pyy, sxx, syy, vxx, vyy;

    // F4: P, Q, V
    dpct_pkg::in_item_t f4_item_reg;
    logic [PM-1:0] f4_pmag_reg, f4_q_reg, f4_v_reg;
    logic          f4_never_reg;
    logic [PSW-1:0] p_c;
    logic [QSW-1:0] q_c;
    logic [PM:0]    v_c;

    // F5, F6 ride alongside the second multipliers
    dpct_pkg::in_item_t f5_item_reg, f6_item_reg;
    logic [PM-1:0] f5_pmag_reg, f6_pmag_reg, f5_q_reg, f6_q_reg;
    logic          f5_never_reg, f6_never_reg;
    logic [DW-1:0] pp, qv;

    // F7: discriminant
    dpct_pkg::bridge_t f7_reg;
    logic [DW:0]       d_c;

    assign en         = !(vld_reg[LAST] && full);
    assign pair_stall = !en;
    assign push       = vld_reg[LAST] && !full;
    assign push_data  = f7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAST-1:0], pair_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        r2_reg <= radius * radius;
    end

    always_comb
    begin
        diff_c[0] = {pair.pos_x_a[W-1], pair.pos_x_a} - {pair.pos_x_b[W-1], pair.pos_x_b};
        diff_c[1] = {pair.pos_y_a[W-1], pair.pos_y_a} - {pair.pos_y_b[W-1], pair.pos_y_b};
        diff_c[2] = {pair.vel_x_a[W-1], pair.vel_x_a} - {pair.vel_x_b[W-1], pair.vel_x_b};
        diff_c[3] = {pair.vel_y_a[W-1], pair.vel_y_a} - {pair.vel_y_b[W-1], pair.vel_y_b};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_item_reg <= pair;
            for (int i = 0; i < 4; i++)
            begin
                sgn_reg[i] <= diff_c[i][MW-1];
                mag_reg[i] <= diff_c[i][MW-1] ? -diff_c[i] : diff_c[i];
            end
        end
    end

    dpct_mul #(.AW(MW), .BW(MW)) u_mul_pxx (.clk(clk), .en(en), .a(mag_reg[0]), .b(mag_reg[2]), .p(pxx));
    dpct_mul #(.AW(MW), .BW(MW)) u_mul_pyy (.clk(clk), .en(en), .a(mag_reg[1]), .b(mag_reg[3]), .p(pyy));
    dpct_mul #(.AW(MW), .BW(MW)) u_mul_sxx (.clk(clk), .en(en), .a(mag_reg[0]), .b(mag_reg[0]), .p(sxx));
    dpct_mul #(.AW(MW), .BW(MW)) u_mul_syy (.clk(clk), .en(en), .a(mag_reg[1]), .b(mag_reg[1]), .p(syy));
    dpct_mul #(.AW(MW), .BW(MW)) u_mul_vxx (.clk(clk), .en(en), .a(mag_reg[2]), .b(mag_reg[2]), .p(vxx));
    dpct_mul #(.AW(MW), .BW(MW)) u_mul_vyy (.clk(clk), .en(en), .a(mag_reg[3]), .b(mag_reg[3]), .p(vyy));

    always_comb
    begin
        p_c = (f3_sgn_reg[0] ? -{1'b0, pxx} : {1'b0, pxx})
            + (f3_sgn_reg[1] ? -{1'b0, pyy} : {1'b0, pyy});
        q_c = QSW'(sxx) + QSW'(syy) - QSW'({r2_reg, 2'b00});
        v_c = (PM+1)'(vxx) + (PM+1)'(vyy);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f2_item_reg  <= f1_item_reg;
            f2_sgn_reg   <= {sgn_reg[1] ^ sgn_reg[3], sgn_reg[0] ^ sgn_reg[2]};
            f3_item_reg  <= f2_item_reg;
            f3_sgn_reg   <= f2_sgn_reg;

            f4_item_reg  <= f3_item_reg;
            f4_pmag_reg  <= p_c[PSW-1] ? PM'(-p_c) : p_c[PM-1:0];
            f4_q_reg     <= q_c[QSW-1] ? '0 : q_c[PM-1:0];
            f4_v_reg     <= v_c[PM-1:0];
            // moving apart, or already overlapping
            f4_never_reg <= (!p_c[PSW-1] && (p_c != '0)) || q_c[QSW-1];

            f5_item_reg  <= f4_item_reg;
            f5_pmag_reg  <= f4_pmag_reg;
            f5_q_reg     <= f4_q_reg;
            f5_never_reg <= f4_never_reg;
            f6_item_reg  <= f5_item_reg;
            f6_pmag_reg  <= f5_pmag_reg;
            f6_q_reg     <= f5_q_reg;
            f6_never_reg <= f5_never_reg;

            f7_reg.item  <= f6_item_reg;
            f7_reg.p_mag <= f6_pmag_reg;
            f7_reg.q     <= f6_q_reg;
            f7_reg.d     <= d_c[DW-1:0];
            f7_reg.never <= f6_never_reg || d_c[DW];
        end
    end

    dpct_mul #(.AW(PM), .BW(PM)) u_mul_pp (.clk(clk), .en(en), .a(f4_pmag_reg), .b(f4_pmag_reg), .p(pp));
    dpct_mul #(.AW(PM), .BW(PM)) u_mul_qv (.clk(clk), .en(en), .a(f4_q_reg), .b(f4_v_reg), .p(qv));

    assign d_c = {1'b0, pp} - {1'b0, qv};

endmodule

[sv/dpct_fifo.sv]
`timescale 1ns / 1ps
// dpct_fifo: short first-word-fall-through queue of classified pairs between front and back.
// Depends on dpct_pkg.

module dpct_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dpct_pkg::bridge_t push_data,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output dpct_pkg::bridge_t head
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    dpct_pkg::bridge_t entry_reg [0:DEPTH-1];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;

    assign full      = (count_reg == (AW+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[sv/dpct_back.sv]
`timescale 1ns / 1ps
// dpct_back: pipelined square root, division, contact box test and output register.
// Depends on dpct_pkg and dpct_mul.

module dpct_back #(
    parameter int FRAC_BITS = dpct_pkg::FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  dpct_pkg::bridge_t   q_data,
    output logic                pop,
    input  dpct_pkg::cfg_t      cfg,
    output logic                hit_valid,
    input  logic                hit_stall,
    output dpct_pkg::out_item_t hit
);
    localparam int W    = dpct_pkg::WORD_BITS;
    localparam int PM   = dpct_pkg::PMAG_BITS;
    localparam int DW   = dpct_pkg::D_BITS;
    localparam int RW   = dpct_pkg::ROOT_BITS;
    localparam int CB   = dpct_pkg::CFG_BITS;
    localparam int DNW  = ((RW > PM) ? RW : PM) + 1;
    localparam int NW   = PM + FRAC_BITS;
    localparam int CW   = ((NW > DNW + W) ? NW : DNW + W) + 1;
    localparam int OW0  = (W + FRAC_BITS > 2 * W + 1) ? W + FRAC_BITS : 2 * W + 1;
    localparam int OW   = ((OW0 > CB + FRAC_BITS) ? OW0 : CB + FRAC_BITS) + 2;
    localparam int TS   = RW + W + 2;
    localparam int LAST = TS + 3;

    typedef struct packed {
        dpct_pkg::in_item_t item;
        logic [PM-1:0]      p_mag;
        logic [PM-1:0]      q;
        logic               never;
    } pay_t;

    logic          en;
    logic [LAST:0] vld_reg;

    // square root section
    pay_t          sq_pay_reg  [0:RW];
    logic [RW+1:0] sq_rem_reg  [0:RW];
    logic [RW-1:0] sq_root_reg [0:RW];
    logic [DW-1:0] sq_d_reg    [0:RW];

    // division section
    pay_t           dv_pay_reg [0:W];
    logic [CW-1:0]  dv_rem_reg [0:W];
    logic [DNW-1:0] dv_den_reg [0:W];
    logic [W-1:0]   dv_quo_reg [0:W];
    logic           dv_sat_reg [0:W];
    logic [DNW-1:0] den_c;
    logic [CW-1:0]  num_c;

    // time and box test
    pay_t           ts_pay_reg, m1_pay_reg, m2_pay_reg;
    logic [W-1:0]   ts_t_reg, m1_t_reg, m2_t_reg;
    logic [W-1:0]   vmag [0:3];
    logic [2*W-1:0] prod [0:3];
    logic           out_never;
    dpct_pkg::out_item_t hit_reg;

    assign en        = !vld_reg[LAST] || !hit_stall;
    assign pop       = en && q_valid;
    assign hit_valid = vld_reg[LAST];
    assign hit       = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAST-1:0], q_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_pay_reg[0]  <= '{item: q_data.item, p_mag: q_data.p_mag, q: q_data.q,
                               never: q_data.never};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_d_reg[0]    <= q_data.d;
        end
    end

    // one root bit per stage, two radicand bits consumed
    for (genvar k = 1; k <= RW; k++)
    begin : g_sqrt
        logic [RW+3:0] cat;
        logic [RW+3:0] trial;
        logic          ge;

        always_comb
        begin
            cat   = {sq_rem_reg[k-1], sq_d_reg[k-1][DW-1 -: 2]};
            trial = {2'b00, sq_root_reg[k-1], 2'b01};
            ge    = (cat >= trial);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_pay_reg[k]  <= sq_pay_reg[k-1];
                sq_rem_reg[k]  <= ge ? (RW+2)'(cat - trial) : cat[RW+1:0];
                sq_root_reg[k] <= {sq_root_reg[k-1][RW-2:0], ge};
                sq_d_reg[k]    <= sq_d_reg[k-1] << 2;
            end
        end
    end

    always_comb
    begin
        den_c = DNW'(sq_root_reg[RW]) + DNW'(sq_pay_reg[RW].p_mag);
        num_c = CW'({sq_pay_reg[RW].q, {FRAC_BITS{1'b0}}});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_pay_reg[0].item  <= sq_pay_reg[RW].item;
            dv_pay_reg[0].p_mag <= sq_pay_reg[RW].p_mag;
            dv_pay_reg[0].q     <= sq_pay_reg[RW].q;
            dv_pay_reg[0].never <= sq_pay_reg[RW].never || (den_c == '0);
            dv_rem_reg[0]       <= num_c;
            dv_den_reg[0]       <= den_c;
            dv_quo_reg[0]       <= '0;
            // quotient would need more than W bits
            dv_sat_reg[0]       <= (num_c >= (CW'(den_c) << W));
        end
    end

    // restoring division, one quotient bit per stage from the top
    for (genvar k = 1; k <= W; k++)
    begin : g_div
        logic [CW-1:0] sub;
        logic          ge;

        always_comb
        begin
            sub = CW'(dv_den_reg[k-1]) << (W - k);
            ge  = (dv_rem_reg[k-1] >= sub);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_pay_reg[k] <= dv_pay_reg[k-1];
                dv_rem_reg[k] <= ge ? dv_rem_reg[k-1] - sub : dv_rem_reg[k-1];
                dv_den_reg[k] <= dv_den_reg[k-1];
                dv_quo_reg[k] <= {dv_quo_reg[k-1][W-2:0], ge};
                dv_sat_reg[k] <= dv_sat_reg[k-1];
            end
        end
    end

    always_comb
    begin
        vmag[0] = ts_pay_reg.item.vel_x_a[W-1] ? W'(-ts_pay_reg.item.vel_x_a)
                                                : ts_pay_reg.item.vel_x_a;
        vmag[1] = ts_pay_reg.item.vel_x_b[W-1] ? W'(-ts_pay_reg.item.vel_x_b)
                                                : ts_pay_reg.item.vel_x_b;
        vmag[2] = ts_pay_reg.item.vel_y_a[W-1] ? W'(-ts_pay_reg.item.vel_y_a)
                                                : ts_pay_reg.item.vel_y_a;
        vmag[3] = ts_pay_reg.item.vel_y_b[W-1] ? W'(-ts_pay_reg.item.vel_y_b)
                                                : ts_pay_reg.item.vel_y_b;
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_vmul
        dpct_mul #(.AW(W), .BW(W)) u_mul (
            .clk(clk), .en(en), .a(vmag[i]), .b(ts_t_reg), .p(prod[i])
        );
    end

    // |pos*S + vel*t| > lim*S, exact
    function automatic logic outside_f(
        input logic [W-1:0]   pos,
        input logic           vneg,
        input logic [2*W-1:0] pv,
        input logic [CB-1:0]  lim
    );
        logic [OW-1:0] xs;
        logic [OW-1:0] sum;
        logic [OW-1:0] mag;
        logic [OW-1:0] lw;
        xs  = OW'(signed'(pos)) << FRAC_BITS;
        sum = vneg ? xs - OW'(pv) : xs + OW'(pv);
        mag = sum[OW-1] ? -sum : sum;
        lw  = OW'(lim) << FRAC_BITS;
        return mag > lw;
    endfunction

    always_comb
    begin
        out_never = m2_pay_reg.never
            || outside_f(m2_pay_reg.item.pos_x_a, m2_pay_reg.item.vel_x_a[W-1], prod[0],
                         cfg.half_width)
            || outside_f(m2_pay_reg.item.pos_x_b, m2_pay_reg.item.vel_x_b[W-1], prod[1],
                         cfg.half_width)
            || outside_f(m2_pay_reg.item.pos_y_a, m2_pay_reg.item.vel_y_a[W-1], prod[2],
                         cfg.half_height)
            || outside_f(m2_pay_reg.item.pos_y_b, m2_pay_reg.item.vel_y_b[W-1], prod[3],
                         cfg.half_height);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ts_pay_reg <= dv_pay_reg[W];
            ts_t_reg   <= dv_sat_reg[W] ? '1 : dv_quo_reg[W];
            m1_pay_reg <= ts_pay_reg;
            m1_t_reg   <= ts_t_reg;
            m2_pay_reg <= m1_pay_reg;
            m2_t_reg   <= m1_t_reg;
            hit_reg.never    <= out_never;
            hit_reg.hit_time <= out_never ? '0 : m2_t_reg;
        end
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for disk_pair_collision_time_core.
// Depends on dpct_pkg and the core. Pair transfers are predicted with exact wide
// arithmetic and every hit transfer is checked, in order, against the prediction.

module testbench;

    typedef logic signed [255:0] wide_t;

    // Collision time predictor plus queue of predicted hits
    class hit_scoreboard;
        dpct_pkg::cfg_t      regs;
        dpct_pkg::out_item_t due_q[$];
        int                  errors;

        function new();
            regs.radius      = dpct_pkg::RADIUS_RST;
            regs.half_width  = dpct_pkg::HALF_WIDTH_RST;
            regs.half_height = dpct_pkg::HALF_HEIGHT_RST;
            errors           = 0;
        endfunction

        function void set_reg(logic [dpct_pkg::CFG_IDX_BITS-1:0] idx,
                              logic [dpct_pkg::CFG_BITS-1:0] val);
            // an index beyond the register list is ignored
            if (idx == dpct_pkg::REG_RADIUS)
                regs.radius = val;
            else if (idx == dpct_pkg::REG_HALF_WIDTH)
                regs.half_width = val;
            else if (idx == dpct_pkg::REG_HALF_HEIGHT)
                regs.half_height = val;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // floor(sqrt(n)), bit by bit
        function logic [255:0] int_sqrt(logic [255:0] n);
            logic [255:0] rem;
            logic [255:0] res;
            logic [255:0] bitv;
            rem  = n;
            res  = '0;
            bitv = 256'd1 << 254;
            while (bitv != 0 && bitv > rem)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (rem >= res + bitv)
                begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        // |pos*S + vel*t| > lim*S, all exact
        function bit off_box(logic signed [dpct_pkg::WORD_BITS-1:0] pos,
                             logic signed [dpct_pkg::WORD_BITS-1:0] vel,
                             wide_t t, logic [dpct_pkg::CFG_BITS-1:0] lim);
            wide_t x;
            wide_t l;
            x = (wide_t'(pos) <<< dpct_pkg::FRAC_BITS) + wide_t'(vel) * t;
            if (x < 0)
                x = -x;
            l = wide_t'({1'b0, lim}) <<< dpct_pkg::FRAC_BITS;
            return x > l;
        endfunction

        function dpct_pkg::out_item_t predict(dpct_pkg::in_item_t it);
            wide_t dx, dy, dvx, dvy, p, q, v, d, den, tq, rad;
            dpct_pkg::out_item_t o;
            o.hit_time = '0;
            o.never    = 1'b1;
            dx  = wide_t'(it.pos_x_a) - wide_t'(it.pos_x_b);
            dy  = wide_t'(it.pos_y_a) - wide_t'(it.pos_y_b);
            dvx = wide_t'(it.vel_x_a) - wide_t'(it.vel_x_b);
            dvy = wide_t'(it.vel_y_a) - wide_t'(it.vel_y_b);
            p   = dx * dvx + dy * dvy;
            if (p > 0)
                return o;               // moving apart
            rad = wide_t'({1'b0, regs.radius});
            q   = dx * dx + dy * dy - 4 * rad * rad;
            if (q < 0)
                return o;               // already overlapping
            v = dvx * dvx + dvy * dvy;
            d = p * p - q * v;
            if (d < 0)
                return o;               // paths miss
            den = wide_t'(int_sqrt(d)) - p;
            if (den == 0)
                return o;
            tq = (q <<< dpct_pkg::FRAC_BITS) / den;
            if (tq > wide_t'(64'hFFFF_FFFF))
                tq = wide_t'(64'hFFFF_FFFF);
            if (off_box(it.pos_x_a, it.vel_x_a, tq, regs.half_width) ||
                off_box(it.pos_x_b, it.vel_x_b, tq, regs.half_width) ||
                off_box(it.pos_y_a, it.vel_y_a, tq, regs.half_height) ||
                off_box(it.pos_y_b, it.vel_y_b, tq, regs.half_height))
                return o;
            o.hit_time = tq[dpct_pkg::WORD_BITS-1:0];
            o.never    = 1'b0;
            return o;
        endfunction

        function void note_pair(dpct_pkg::in_item_t it);
            due_q.push_back(predict(it));
        endfunction

        function void check_hit(dpct_pkg::out_item_t got);
            dpct_pkg::out_item_t want;
            if (due_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("hit with nothing due: time=%h never=%b",
                             got.hit_time, got.never);
                return;
            end
            want = due_q.pop_front();
            if (got.hit_time !== want.hit_time || got.never !== want.never)
            begin
                errors++;
                if (errors <= 10)
                    $display("hit mismatch: expected time=%h never=%b, got time=%h never=%b",
                             want.hit_time, want.never, got.hit_time, got.never);
            end
        endfunction
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              pair_valid;
    logic                              pair_stall;
    dpct_pkg::in_item_t                pair;
    logic                              hit_valid;
    logic                              hit_stall;
    dpct_pkg::out_item_t               hit;
    logic                              cfg_we;
    logic [dpct_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [dpct_pkg::CFG_BITS-1:0]     cfg_data;

    hit_scoreboard sb = new();
    int            send_idle_pct;
    int            stall_pct;
    int            quiet_cycles;

    localparam int LATENCY    = 3 * dpct_pkg::WORD_BITS + 24;   // drain wait, with margin over the pipeline depth
    localparam int QUIET_MAX  = 20000;
    // index past the register list
    localparam logic [dpct_pkg::CFG_IDX_BITS-1:0] REG_UNMAPPED = 2'd3;

    disk_pair_collision_time_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair_stall (pair_stall),
        .pair       (pair),
        .hit_valid  (hit_valid),
        .hit_stall  (hit_stall),
        .hit        (hit),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #4 clk = ~clk;

    // Monitors sample pre-edge values; the block updates after them
    always @(posedge clk)
    begin
        if (rst_n && pair_valid && !pair_stall)
            sb.note_pair(pair);
        if (rst_n && hit_valid && !hit_stall)
            sb.check_hit(hit);
    end

    // Receiver back-pressure, driven at the edge
    always @(posedge clk)
    begin
        if (!rst_n)
            hit_stall <= 1'b0;
        else
            hit_stall <= ($urandom_range(99, 0) < stall_pct);
    end

    // Watchdog: too long with no transfer on either channel
    always @(posedge clk)
    begin
        if ((pair_valid && !pair_stall) || (hit_valid && !hit_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Register write; the caller lowers cfg_we after the last one
    task automatic write_reg(logic [dpct_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [dpct_pkg::CFG_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic set_geometry(logic [dpct_pkg::CFG_BITS-1:0] rad,
                                logic [dpct_pkg::CFG_BITS-1:0] hw,
                                logic [dpct_pkg::CFG_BITS-1:0] hh);
        write_reg(dpct_pkg::REG_RADIUS, rad);
        write_reg(dpct_pkg::REG_HALF_WIDTH, hw);
        write_reg(dpct_pkg::REG_HALF_HEIGHT, hh);
        write_reg(REG_UNMAPPED, dpct_pkg::CFG_BITS'($urandom));   // must be ignored
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // One pair transfer, with an optional random gap ahead of it
    task automatic send_pair(dpct_pkg::in_item_t it);
        int gap;
        gap = 0;
        if ($urandom_range(99, 0) < send_idle_pct)
            gap = $urandom_range(6, 1);
        if (gap > 0)
        begin
            pair_valid <= 1'b0;
            pair       <= dpct_pkg::in_item_t'({8{$urandom}});   // junk while idle
            repeat (gap) @(posedge clk);
        end
        pair_valid <= 1'b1;
        pair       <= it;
        @(posedge clk);
        while (pair_stall)
            @(posedge clk);
    endtask

    // Let every predicted hit arrive, then the pipeline settle
    task automatic drain();
        pair_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    function automatic logic signed [dpct_pkg::WORD_BITS-1:0] rnd_span(int bits);
        return $signed($urandom) >>> (32 - bits);
    endfunction

    function automatic dpct_pkg::in_item_t make_pair(
        logic signed [31:0] xa, logic signed [31:0] ya,
        logic signed [31:0] vxa, logic signed [31:0] vya,
        logic signed [31:0] xb, logic signed [31:0] yb,
        logic signed [31:0] vxb, logic signed [31:0] vyb);
        dpct_pkg::in_item_t it;
        it.pos_x_a = xa;  it.pos_y_a = ya;  it.vel_x_a = vxa; it.vel_y_a = vya;
        it.pos_x_b = xb;  it.pos_y_b = yb;  it.vel_x_b = vxb; it.vel_y_b = vyb;
        return it;
    endfunction

    // Mostly approaching pairs near the box, some raw noise
    function automatic dpct_pkg::in_item_t random_pair();
        dpct_pkg::in_item_t it;
        int                 pb, vb, sh, kind;
        kind = $urandom_range(99, 0);
        if (kind < 20)
            return dpct_pkg::in_item_t'({8{$urandom}});
        pb = $urandom_range(26, 17);
        vb = $urandom_range(24, 10);
        sh = $urandom_range(6, 0);
        it.pos_x_a = rnd_span(pb);
        it.pos_y_a = rnd_span(pb);
        it.pos_x_b = it.pos_x_a + rnd_span(pb - 2);
        it.pos_y_b = it.pos_y_a + rnd_span(pb - 2);
        it.vel_x_b = rnd_span(vb);
        it.vel_y_b = rnd_span(vb);
        // relative velocity points roughly from a towards b
        it.vel_x_a = it.vel_x_b - ((it.pos_x_a - it.pos_x_b) >>> sh) + rnd_span(vb - 4);
        it.vel_y_a = it.vel_y_b - ((it.pos_y_a - it.pos_y_b) >>> sh) + rnd_span(vb - 4);
        if (kind < 30)
            it.vel_y_a = rnd_span(32);   // break the approach on one axis
        return it;
    endfunction

    localparam logic signed [31:0] ONE  = 32'sd65536;
    localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;

    task automatic directed_pairs();
        // overlap: both at the origin
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        // head-on along x, gap 10, closing speed 2
        send_pair(make_pair(-5*ONE, 0, ONE, 0, 5*ONE, 0, -ONE, 0));
        // head-on along y with a fractional time
        send_pair(make_pair(0, 3*ONE, 0, -ONE/3, 0, -4*ONE, 0, ONE/7));
        // moving apart
        send_pair(make_pair(-5*ONE, 0, -ONE, 0, 5*ONE, 0, ONE, 0));
        // parallel paths that miss
        send_pair(make_pair(-5*ONE, 0, ONE, 0, 5*ONE, 4*ONE, -ONE, 0));
        // no relative motion at all
        send_pair(make_pair(-5*ONE, ONE, 7, 9, 5*ONE, 2*ONE, 7, 9));
        // just touching and closing: time zero
        send_pair(make_pair(-ONE, 0, ONE, 0, ONE, 0, 0, 0));
        // crawling together from far: time saturates
        send_pair(make_pair(-90*ONE, 0, 1, 0, 90*ONE, 0, 0, 0));
        // fast approach towards a disk at rest, in x and in y
        send_pair(make_pair(50*ONE, 0, 40*ONE, 0, 90*ONE, 0, 0, 0));
        send_pair(make_pair(0, 50*ONE, 0, 40*ONE, 0, 90*ONE, 0, 0));
        // field extremes
        send_pair(make_pair(SMAX, SMAX, SMIN, SMIN, SMIN, SMIN, SMAX, SMAX));
        send_pair(make_pair(SMIN, SMIN, SMAX, SMAX, SMAX, SMAX, SMIN, SMIN));
        send_pair(make_pair(SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, SMIN));
        send_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
        send_pair(make_pair(SMIN, 0, SMAX, 0, SMAX, 0, SMIN, 0));
        // glancing approach
        send_pair(make_pair(-5*ONE, ONE, ONE, 0, 5*ONE, -ONE, -ONE, 0));
    endtask

    task automatic random_phase(int n);
        repeat (n) send_pair(random_pair());
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        pair_valid    = 1'b0;
        pair          = '0;
        hit_stall     = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        quiet_cycles  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry first, then the directed pairs with extreme settings
        directed_pairs();
        drain();
        set_geometry(31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        directed_pairs();
        drain();
        set_geometry(31'h7FFF_FFFF, 31'd0, 31'd0);
        directed_pairs();
        drain();

        // random phases, each with its own idling and geometry
        set_geometry(31'($urandom_range(1 << 20, 1 << 14)), 31'($urandom_range(1 << 28, 1 << 22)),
                     31'($urandom_range(1 << 28, 1 << 22)));
        random_phase(440);
        drain();
        send_idle_pct = 65;
        set_geometry(dpct_pkg::RADIUS_RST, dpct_pkg::HALF_WIDTH_RST, dpct_pkg::HALF_HEIGHT_RST);
        random_phase(440);
        drain();
        send_idle_pct = 0;
        stall_pct     = 65;
        set_geometry(31'($urandom_range(1 << 18, 0)), 31'h7FFF_FFFF, 31'($urandom));
        random_phase(440);
        drain();
        send_idle_pct = 9;
        stall_pct     = 9;
        set_geometry(31'($urandom_range(1 << 19, 1 << 15)), 31'($urandom_range(1 << 27, 1 << 20)),
                     31'($urandom_range(1 << 27, 1 << 20)));
        random_phase(380);
        drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
